// ===== rtl/core/tlbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbf_pkg
// Shared types and constants for the FIFO-replacement translation buffer.
// ----------------------------------------------------------------------------
package tlbf_pkg;

    // Field widths of the item, result and configuration channels.
    localparam int PAGE_W  = 20;
    localparam int FRAME_W = 16;
    localparam int CFG_W   = 5;

    // Reset value of the entries_in_use register.
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Operation codes carried by the func field.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_RESOLVE,
        ST_ACCESS,
        ST_OUT
    } tlbf_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_write;
        logic load_in;
        logic match;
        logic resolve;
        logic access;
    } tlbf_cmd_t;

endpackage

// ===== rtl/core/tlbf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbf_ctrl
// Controller state machine: sequences one item through compare, resolve and
// frame access, then holds the result until the downstream transfer.
// ----------------------------------------------------------------------------
module tlbf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    output tlbf_pkg::tlbf_cmd_t cmd
);
    import tlbf_pkg::*;

    tlbf_state_t state_reg;
    tlbf_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cfg_ready     = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cfg_ready     = 1'b1;
                cmd.cfg_write = cfg_valid;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmd.match  = 1'b1;
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                cmd.resolve = 1'b1;
                state_next  = ST_ACCESS;
            end
            ST_ACCESS: begin
                cmd.access = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/tlbf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbf_datapath
// Entry store, parallel tag compare, FIFO replacement pointers and the frame
// memory, driven step by step by the controller commands.
// ----------------------------------------------------------------------------
module tlbf_datapath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tlbf_pkg::tlbf_cmd_t          cmd,
    input  logic [tlbf_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_func,
    input  logic [tlbf_pkg::PAGE_W-1:0]  s_page_number,
    input  logic [tlbf_pkg::FRAME_W-1:0] s_frame_number,
    output logic                         m_hit,
    output logic [tlbf_pkg::FRAME_W-1:0] m_frame_out
);
    import tlbf_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CAP_RESET =
        (MAX_ENTRIES < 32'(CFG_RESET)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(CFG_RESET);

    // Latched item.
    logic               func_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [FRAME_W-1:0] frame_reg;

    // Entry store: valid bits, tags compared in parallel, frames in memory.
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [PAGE_W-1:0]      page_store [MAX_ENTRIES];
    logic [FRAME_W-1:0]     frame_mem  [MAX_ENTRIES];

    // Replacement state and effective capacity.
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;
    logic [CNT_W-1:0] filled_reg;
    logic [IDX_W-1:0] oldest_reg;

    // Compare and resolve results.
    logic [MAX_ENTRIES-1:0] match_reg;
    logic [IDX_W-1:0]       match_idx;
    logic                   match_any;
    logic [IDX_W-1:0]       slot_reg;
    logic                   hit_reg;
    logic                   show_reg;
    logic [FRAME_W-1:0]     frame_rd_reg;

    // Replacement target for a new page.
    logic [CNT_W-1:0] victim;
    logic [CNT_W-1:0] victim_inc;
    logic             has_free;

    // Clamp the written capacity to the range 1 to MAX_ENTRIES.
    always_comb begin
        if (cfg_data == '0) begin
            cap_next = CNT_W'(1);
        end else if (32'(cfg_data) > 32'(MAX_ENTRIES)) begin
            cap_next = CNT_W'(MAX_ENTRIES);
        end else begin
            cap_next = CNT_W'(cfg_data);
        end
    end

    // Pages are unique among valid entries, so the match vector is one-hot
    // or empty and its index is an OR of the matching positions.
    always_comb begin
        match_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match_reg[i]) begin
                match_idx = match_idx | IDX_W'(i);
            end
        end
        match_any = |match_reg;
    end

    // Free slot while filling, otherwise the oldest entry.
    always_comb begin
        has_free = (filled_reg < cap_reg);
        if (CNT_W'(oldest_reg) >= cap_reg) begin
            victim = '0;
        end else begin
            victim = CNT_W'(oldest_reg);
        end
        victim_inc = victim + CNT_W'(1);
    end

    // Item capture.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg  <= s_func;
            page_reg  <= s_page_number;
            frame_reg <= s_frame_number;
        end
    end

    // Parallel tag compare.
    always_ff @(posedge aclk) begin
        if (cmd.match) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                match_reg[i] <= valid_reg[i] && (page_store[i] == page_reg);
            end
        end
    end

    // Control state: capacity, valid bits and FIFO pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_RESET;
            valid_reg  <= '0;
            filled_reg <= '0;
            oldest_reg <= '0;
        end else if (cmd.cfg_write) begin
            cap_reg    <= cap_next;
            valid_reg  <= '0;
            filled_reg <= '0;
            oldest_reg <= '0;
        end else if (cmd.resolve && func_reg == FUNC_INSERT && !match_any) begin
            if (has_free) begin
                valid_reg[filled_reg[IDX_W-1:0]] <= 1'b1;
                filled_reg <= filled_reg + CNT_W'(1);
            end else begin
                valid_reg[victim[IDX_W-1:0]] <= 1'b1;
                if (victim_inc >= cap_reg) begin
                    oldest_reg <= '0;
                end else begin
                    oldest_reg <= victim_inc[IDX_W-1:0];
                end
            end
        end
    end

    // Resolve: pick the slot, store the tag of a new page.
    always_ff @(posedge aclk) begin
        if (cmd.resolve) begin
            hit_reg  <= match_any;
            show_reg <= match_any && (func_reg == FUNC_LOOKUP);
            if (func_reg == FUNC_INSERT && !match_any) begin
                if (has_free) begin
                    slot_reg <= filled_reg[IDX_W-1:0];
                    page_store[filled_reg[IDX_W-1:0]] <= page_reg;
                end else begin
                    slot_reg <= victim[IDX_W-1:0];
                    page_store[victim[IDX_W-1:0]] <= page_reg;
                end
            end else begin
                slot_reg <= match_idx;
            end
        end
    end

    // Frame memory: one read and one write port, registered read data.
    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            frame_rd_reg <= frame_mem[slot_reg];
            if (func_reg == FUNC_INSERT) begin
                frame_mem[slot_reg] <= frame_reg;
            end
        end
    end

    // Result: the frame is shown only on a lookup hit.
    assign m_hit       = hit_reg;
    assign m_frame_out = show_reg ? frame_rd_reg : '0;

endmodule

// ===== rtl/core/tlb_fifo_replacement.sv =====
`timescale 1ns / 1ps
// A result is valid once the controller has stepped through its match, resolve
// and access states after the item transfer; no new item is taken until the
// result has been taken and the controller is back in its idle state.
// Reset: synchronous, active low; all entries invalid, capacity 16 (or
// MAX_ENTRIES if smaller). A configuration write also flushes all entries.
// ----------------------------------------------------------------------------
// tlb_fifo_replacement
// Fully associative translation buffer with first-in-first-out replacement.
// ----------------------------------------------------------------------------
module tlb_fifo_replacement #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tlbf_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [tlbf_pkg::PAGE_W-1:0]  s_page_number,
    input  logic [tlbf_pkg::FRAME_W-1:0] s_frame_number,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [tlbf_pkg::FRAME_W-1:0] m_frame_out
);
    import tlbf_pkg::*;

    tlbf_cmd_t cmd;

    // Sequencer.
    tlbf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // Entry store and replacement logic.
    tlbf_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_data       (cfg_data),
        .s_func         (s_func),
        .s_page_number  (s_page_number),
        .s_frame_number (s_frame_number),
        .m_hit          (m_hit),
        .m_frame_out    (m_frame_out)
    );

endmodule

// ===== bench/tlb_fifo_replacement_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_fifo_replacement_tb
// Self-checking bench for the FIFO-replacement translation buffer. A local
// copy of the buffer predicts hit and frame for every item transfer. Each
// result transfer is compared with the oldest prediction. Directed items cover
// empty lookups, duplicate inserts, eviction order, flush on a capacity write
// and out-of-range capacities. One test holds the receiver off for a long
// stretch. Random traffic over a small page pool then runs under several
// capacities, with random idling on both sides.
// ----------------------------------------------------------------------------
module tlb_fifo_replacement_tb;

    import tlbf_pkg::*;

    localparam int NUM_SLOTS      = 16;
    localparam int IDLE_PERCENT   = 18;
    localparam int STALL_LIMIT    = 5000;
    localparam int ITEMS_PER_STEP = 210;

    typedef struct {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
    } xlat_result_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_func;
    logic [PAGE_W-1:0]  s_page_number;
    logic [FRAME_W-1:0] s_frame_number;
    logic               m_valid;
    logic               m_ready;
    logic               m_hit;
    logic [FRAME_W-1:0] m_frame_out;

    // Predicted buffer contents.
    logic               slot_valid [NUM_SLOTS];
    logic [PAGE_W-1:0]  slot_page  [NUM_SLOTS];
    logic [FRAME_W-1:0] slot_frame [NUM_SLOTS];
    int                 oldest_slot;
    int                 filled_count;
    logic [CFG_W-1:0]   entries_in_use;

    xlat_result_t       expected_translations [$];
    int                 error_count = 0;
    int                 stall_cycles = 0;
    bit                 tx_idle_on = 1'b1;
    bit                 rx_idle_on = 1'b1;
    int                 rx_hold_len = 0;

    tlb_fifo_replacement #(
        .MAX_ENTRIES    (NUM_SLOTS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_page_number  (s_page_number),
        .s_frame_number (s_frame_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_frame_out    (m_frame_out)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Capacity as the buffer applies it: zero acts as one, large values clip.
    function automatic int effective_capacity();
        int c;
        c = entries_in_use;
        if (c < 1) c = 1;
        if (c > NUM_SLOTS) c = NUM_SLOTS;
        return c;
    endfunction

    function automatic void flush_buffer();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_page[i]  = '0;
            slot_frame[i] = '0;
        end
        oldest_slot  = 0;
        filled_count = 0;
    endfunction

    // Works out the result of one item and updates the predicted buffer.
    function automatic xlat_result_t predict_translation(logic func,
                                                         logic [PAGE_W-1:0] page,
                                                         logic [FRAME_W-1:0] frame);
        xlat_result_t res;
        int slot;
        int target;
        int cap;
        slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot < 0 && slot_valid[i] && slot_page[i] == page) slot = i;
        end
        res.hit       = (slot >= 0);
        res.frame_out = '0;
        if (func == FUNC_LOOKUP) begin
            if (slot >= 0) res.frame_out = slot_frame[slot];
        end else if (slot >= 0) begin
            // A page already present only gets its frame refreshed.
            slot_frame[slot] = frame;
        end else begin
            cap = effective_capacity();
            if (filled_count < cap) begin
                target = filled_count;
                filled_count++;
            end else begin
                target = oldest_slot;
                if (target >= cap) target = 0;
                oldest_slot = target + 1;
                if (oldest_slot >= cap) oldest_slot = 0;
            end
            slot_valid[target] = 1'b1;
            slot_page[target]  = page;
            slot_frame[target] = frame;
        end
        return res;
    endfunction

    // Offers one item, with an optional random gap first, and records the
    // prediction at the edge where the transfer happens.
    task automatic send_item(input logic func, input logic [PAGE_W-1:0] page,
                             input logic [FRAME_W-1:0] frame);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) gap = $urandom_range(6, 1);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_page_number  <= page;
        s_frame_number <= frame;
        do @(posedge aclk); while (!s_ready);
        expected_translations.insert(expected_translations.size(),
                                     predict_translation(func, page, frame));
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        idle_input();
        while (expected_translations.size() != 0) @(posedge aclk);
    endtask

    // Writes entries_in_use once the buffer has nothing in flight.
    task automatic write_entries_in_use(input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        entries_in_use = value;
        flush_buffer();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [FRAME_W-1:0] random_frame();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return FRAME_W'($urandom);
    endfunction

    // Field extremes, hits and misses, and a duplicate insert at reset capacity.
    task automatic test_lookup_insert_basics();
        send_item(FUNC_LOOKUP, '0, '1);
        send_item(FUNC_INSERT, '0, '1);
        send_item(FUNC_INSERT, '1, '0);
        send_item(FUNC_LOOKUP, '0, '0);
        send_item(FUNC_LOOKUP, '1, '1);
        send_item(FUNC_INSERT, '0, 16'h1234);
        send_item(FUNC_LOOKUP, '0, '0);
        send_item(FUNC_LOOKUP, 20'h12345, '0);
    endtask

    // Eviction order at a small capacity, flush on write, and out-of-range values.
    task automatic test_capacity_limits();
        write_entries_in_use(5'd2);
        send_item(FUNC_INSERT, 20'h00a11, 16'h0a11);
        send_item(FUNC_INSERT, 20'h00b22, 16'h0b22);
        send_item(FUNC_INSERT, 20'h00c33, 16'h0c33);
        send_item(FUNC_LOOKUP, 20'h00a11, '0);
        send_item(FUNC_LOOKUP, 20'h00b22, '0);
        send_item(FUNC_LOOKUP, 20'h00c33, '0);
        send_item(FUNC_INSERT, 20'h00d44, 16'h0d44);
        send_item(FUNC_LOOKUP, 20'h00b22, '0);

        // Zero behaves as a single entry; the write also empties the buffer.
        write_entries_in_use(5'd0);
        send_item(FUNC_LOOKUP, 20'h00d44, '0);
        send_item(FUNC_INSERT, 20'h00e55, 16'h0e55);
        send_item(FUNC_INSERT, 20'h00f66, 16'h0f66);
        send_item(FUNC_LOOKUP, 20'h00e55, '0);

        // The largest value clips to the number of slots.
        write_entries_in_use(5'd31);
        send_item(FUNC_INSERT, 20'h5a5a5, 16'ha5a5);
        send_item(FUNC_LOOKUP, 20'h5a5a5, '0);
        send_item(FUNC_LOOKUP, 20'ha5a5a, '0);
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_receiver_backpressure();
        tx_idle_on  = 1'b0;
        rx_hold_len = 300;
        for (int i = 0; i < 30; i++) begin
            send_item((i % 2 == 0) ? FUNC_INSERT : FUNC_LOOKUP,
                      PAGE_W'(i / 2), random_frame());
        end
        tx_idle_on = 1'b1;
    endtask

    // Random traffic over a page pool a little larger than the capacity.
    task automatic test_random_traffic();
        logic [CFG_W-1:0]  caps [8] = '{5'd16, 5'd5, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd12};
        logic [PAGE_W-1:0] pool [24];
        logic [PAGE_W-1:0] page;
        logic              func;
        int                pool_size;
        for (int p = 0; p < 8; p++) begin
            write_entries_in_use(caps[p]);
            pool_size = effective_capacity() + $urandom_range(6, 1);
            for (int k = 0; k < pool_size; k++) pool[k] = PAGE_W'($urandom);
            if (p % 2 == 0) begin
                pool[0] = '0;
                pool[1] = '1;
            end
            // One step runs with no idling on either side.
            tx_idle_on = (p != 4);
            rx_idle_on = (p != 4);
            for (int n = 0; n < ITEMS_PER_STEP; n++) begin
                func = ($urandom_range(99) < 45) ? FUNC_INSERT : FUNC_LOOKUP;
                if ($urandom_range(99) < 90) page = pool[$urandom_range(pool_size - 1)];
                else page = PAGE_W'($urandom);
                send_item(func, page, random_frame());
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Result-side ready: random idling, or a long hold when one is requested.
    always begin : drive_result_ready
        int n;
        @(negedge aclk);
        if (rx_hold_len > 0) begin
            n = rx_hold_len;
            rx_hold_len = 0;
            m_ready <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end else if (rx_idle_on) begin
            m_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge aclk) begin : check_results
        xlat_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_translations.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual hit=%0b frame=%h",
                         $time, m_hit, m_frame_out);
                error_count++;
            end else begin
                want = expected_translations[0];
                expected_translations.delete(0);
                if (m_hit !== want.hit) begin
                    $display("%0t: hit mismatch: expected %0b, actual %0b",
                             $time, want.hit, m_hit);
                    error_count++;
                end
                if (m_frame_out !== want.frame_out) begin
                    $display("%0t: frame_out mismatch: expected %h, actual %h",
                             $time, want.frame_out, m_frame_out);
                    error_count++;
                end
            end
        end
    end

    // Stop the run if no transfer happens on any channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tlb_fifo_replacement_tb: errors");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_func         = FUNC_LOOKUP;
        s_page_number  = '0;
        s_frame_number = '0;
        m_ready        = 1'b0;
        entries_in_use = CFG_RESET;
        flush_buffer();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_lookup_insert_basics();
        test_capacity_limits();
        test_receiver_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("tlb_fifo_replacement_tb: clean");
        end else begin
            $display("tlb_fifo_replacement_tb: errors");
        end
        $finish;
    end

endmodule
